/* design/kmcd_pkg.sv */
// ----------------------------------------------------------------------------
// kmcd_pkg
// Shared types and constants of the key matrix change detector.
// ----------------------------------------------------------------------------
package kmcd_pkg;

	localparam int KEYS_PER_ROW = 8;
	localparam int POS_W        = 3;
	localparam int ROW_BITS_W   = 8;
	localparam int CODE_W       = 8;

	// word opcodes
	localparam logic OP_ROW   = 1'b0;
	localparam logic OP_TABLE = 1'b1;

	// bit 0x80 of a row is key position 0
	localparam logic [ROW_BITS_W-1:0] TOP_BIT = 8'h80;

	typedef struct packed {
		logic                  seen;
		logic [ROW_BITS_W-1:0] prev;
	} row_rd_t;

	typedef struct packed {
		logic [CODE_W-1:0] scancode;
		logic              pressed;
		logic              last;
	} key_evt_t;

endpackage

/* design/kmcd_row_store.sv */
// ----------------------------------------------------------------------------
// kmcd_row_store
// Previous value of each matrix row in a synchronous memory, plus one
// seen flag per row held in flops and cleared by reset.
// ----------------------------------------------------------------------------
module kmcd_row_store
	import kmcd_pkg::*;
#(
	parameter int ROWS = 16,
	parameter int RW   = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [RW-1:0]         rd_row,
	output row_rd_t               rd_data,
	input  logic                  wr_en,
	input  logic [RW-1:0]         wr_row,
	input  logic [ROW_BITS_W-1:0] wr_bits
);

	logic [ROW_BITS_W-1:0] mem [ROWS];
	logic [ROWS-1:0]       seen_q;
	logic [ROW_BITS_W-1:0] prev_q;
	logic                  rd_seen_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_bits;
		end
		if (rd_en) begin
			prev_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			rd_seen_q <= 1'b0;
		end else begin
			if (wr_en) begin
				seen_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_seen_q <= seen_q[rd_row];
			end
		end
	end

	assign rd_data.seen = rd_seen_q;
	assign rd_data.prev = prev_q;

endmodule

/* design/kmcd_code_table.sv */
// ----------------------------------------------------------------------------
// kmcd_code_table
// Scancode table, one entry per key, in a synchronous memory with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module kmcd_code_table
	import kmcd_pkg::*;
#(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CODE_W-1:0] wr_code,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [CODE_W-1:0] rd_code
);

	logic [CODE_W-1:0] mem [DEPTH];
	logic [CODE_W-1:0] rd_code_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_code;
		end
		if (rd_en) begin
			rd_code_q <= mem[rd_addr];
		end
	end

	assign rd_code = rd_code_q;

endmodule

/* design/kmcd_out_fifo.sv */
// ----------------------------------------------------------------------------
// kmcd_out_fifo
// Two-entry output queue for key events; the head drives the output port
// and holds steady while stalled.
// ----------------------------------------------------------------------------
module kmcd_out_fifo
	import kmcd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  key_evt_t push_data,
	output logic     pop,
	output logic [1:0] count,
	output logic     out_valid,
	input  logic     out_stall,
	output key_evt_t out_data
);

	key_evt_t   head_q;
	key_evt_t   tail_q;
	logic [1:0] cnt_q;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign count     = cnt_q;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= push_data;
				end else begin
					tail_q <= push_data;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= tail_q;
					tail_q <= push_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* design/key_matrix_change_detector_top.sv */
// ----------------------------------------------------------------------------
// key_matrix_change_detector_top
// Compares each scanned key matrix row with its previous scan and emits one
// scancode word per changed key; also accepts scancode table writes.
// ----------------------------------------------------------------------------
// A table write word does not stall the input. A row word reads the row memory,
// then compares and writes back, then looks up each changed key; the
// scancode table read port looks up one key per cycle, and key lookups pause when
// the two-entry output queue is full. The next input word is taken once the
// last lookup of the row has returned. The first scan of a row after reset
// only stores it; out-of-range rows and table entries are dropped. No clearing
// pass is needed after reset.
module key_matrix_change_detector_top
	import kmcd_pkg::*;
#(
	parameter int ROWS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [3:0] row_index,
	input  logic [7:0] row_bits,
	input  logic [6:0] table_index,
	input  logic [7:0] table_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] scancode,
	output logic       pressed,
	output logic       last
);

	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW    = RW + POS_W;
	localparam int DEPTH = ROWS * KEYS_PER_ROW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]            st_q;
	logic [RW-1:0]         row_s1;
	logic [ROW_BITS_W-1:0] bits_s1;
	logic [ROW_BITS_W-1:0] diff_q;
	logic                  pend_s1;
	logic                  pressed_s1;
	logic                  last_s1;

	logic                  acc;
	logic                  row_ok;
	logic                  tab_ok;
	logic                  row_rd;
	logic                  tab_wr;
	logic [7:0]            row_ext;
	logic [10:0]           tix_ext;
	row_rd_t               rs_rd;
	logic [ROW_BITS_W-1:0] diff;
	logic                  cmp_wr;
	logic [POS_W-1:0]      pos;
	logic                  found;
	logic [ROW_BITS_W-1:0] mask;
	logic [ROW_BITS_W-1:0] rest;
	logic                  fifo_pop;
	logic [1:0]            fifo_cnt;
	logic [2:0]            occ_next;
	logic                  issue;
	logic [CODE_W-1:0]     tab_code;
	key_evt_t              push_evt;
	key_evt_t              out_evt;

	assign in_stall = !((st_q == ST_IDLE) && !pend_s1);
	assign acc      = in_valid && !in_stall;
	assign row_ok   = {24'd0, row_index} < ROWS;
	assign tab_ok   = {25'd0, table_index} < DEPTH;
	assign row_rd   = acc && (opcode == OP_ROW) && row_ok;
	assign tab_wr   = acc && (opcode == OP_TABLE) && tab_ok;
	assign row_ext  = {4'd0, row_index};
	assign tix_ext  = {4'd0, table_index};

	assign diff   = bits_s1 ^ rs_rd.prev;
	assign cmp_wr = (st_q == ST_CMP);

	// highest changed key first
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = 0; i < KEYS_PER_ROW; i++) begin
			if (!found && diff_q[KEYS_PER_ROW-1-i]) begin
				pos   = POS_W'(i);
				found = 1'b1;
			end
		end
	end

	assign mask = TOP_BIT >> pos;
	assign rest = diff_q & ~mask;

	// room for one more lookup once the queue settles after this edge
	assign occ_next = {1'b0, fifo_cnt} - {2'd0, fifo_pop} + {2'd0, pend_s1};
	assign issue    = (st_q == ST_SCAN) && (occ_next <= 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			case (st_q)
				ST_IDLE: begin
					if (row_rd) begin
						st_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (rs_rd.seen && (diff != '0)) begin
						st_q <= ST_SCAN;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (issue && (rest == '0)) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (row_rd) begin
			row_s1  <= row_ext[RW-1:0];
			bits_s1 <= row_bits;
		end
		if (cmp_wr) begin
			diff_q <= diff;
		end else if (issue) begin
			diff_q <= rest;
		end
		if (issue) begin
			pressed_s1 <= ((bits_s1 & mask) == '0);
			last_s1    <= (rest == '0);
		end
	end

	kmcd_row_store #(
		.ROWS (ROWS),
		.RW   (RW)
	) u_rows (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (row_rd),
		.rd_row  (row_ext[RW-1:0]),
		.rd_data (rs_rd),
		.wr_en   (cmp_wr),
		.wr_row  (row_s1),
		.wr_bits (bits_s1)
	);

	kmcd_code_table #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_codes (
		.clk     (clk),
		.wr_en   (tab_wr),
		.wr_addr (tix_ext[AW-1:0]),
		.wr_code (table_code),
		.rd_en   (issue),
		.rd_addr ({row_s1, pos}),
		.rd_code (tab_code)
	);

	assign push_evt.scancode = tab_code;
	assign push_evt.pressed  = pressed_s1;
	assign push_evt.last     = last_s1;

	kmcd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pend_s1),
		.push_data (push_evt),
		.pop       (fifo_pop),
		.count     (fifo_cnt),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_evt)
	);

	assign scancode = out_evt.scancode;
	assign pressed  = out_evt.pressed;
	assign last     = out_evt.last;

endmodule

/* design/kmcd_checker.sv */
// ----------------------------------------------------------------------------
// kmcd_checker
// Port-level checks of the key matrix change detector, bound to the top.
// ----------------------------------------------------------------------------
module kmcd_checker
	import kmcd_pkg::*;
#(
	parameter int ROWS = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       opcode,
	input logic [3:0] row_index,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] scancode,
	input logic       pressed,
	input logic       last
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({scancode, pressed, last}))
		else $error("result word changed while stalled");

	// an in-range row word always needs the compare cycle
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_ROW) && ({24'd0, row_index} < ROWS)
		|=> in_stall)
		else $error("row word not followed by compare cycle");

	// a table write never blocks the next word
	a_tab_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_TABLE) |=> !in_stall)
		else $error("input stalled after table write");

	// results only come out of a busy scan
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word appeared without a scan in progress");

endmodule

bind key_matrix_change_detector_top kmcd_checker #(.ROWS(ROWS)) u_kmcd_checker (.*);

/* tb/key_event_checker.sv */
// ----------------------------------------------------------------------------
// key_event_checker
// Watches both channels of the key matrix change detector, keeps its own copy
// of the row history and scancode table, and compares every key event word
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module key_event_checker
	import kmcd_pkg::*;
#(
	parameter int ROWS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       opcode,
	input  logic [3:0] row_index,
	input  logic [7:0] row_bits,
	input  logic [6:0] table_index,
	input  logic [7:0] table_code,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] scancode,
	input  logic       pressed,
	input  logic       last,
	output int         mismatches,
	output int         events_pending
);

	logic [ROW_BITS_W-1:0] row_history [ROWS];
	logic                  row_primed  [ROWS];
	logic [CODE_W-1:0]     code_table  [ROWS*KEYS_PER_ROW];
	key_evt_t              upcoming_key_events [$];
	key_evt_t              oldest;

	function automatic void predict_key_events(logic op, logic [3:0] row,
			logic [7:0] bits, logic [6:0] tix, logic [7:0] code);
		logic [7:0] changed;
		logic [7:0] mask;
		int         n_changed;
		int         n_done;
		key_evt_t   evt;
		if (op == OP_TABLE) begin
			if (tix < ROWS*KEYS_PER_ROW)
				code_table[tix] = code;
		end else if (row < ROWS) begin
			if (!row_primed[row]) begin
				// first scan only primes the history
				row_primed[row] = 1'b1;
				row_history[row] = bits;
			end else begin
				changed = bits ^ row_history[row];
				row_history[row] = bits;
				n_changed = $countones(changed);
				n_done = 0;
				for (int pos = 0; pos < KEYS_PER_ROW; pos++) begin
					mask = TOP_BIT >> pos;
					if ((changed & mask) != 0) begin
						n_done++;
						evt.scancode = code_table[row*KEYS_PER_ROW + pos];
						evt.pressed  = ((bits & mask) == 0);
						evt.last     = (n_done == n_changed);
						upcoming_key_events.push_back(evt);
					end
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++)
				row_primed[r] = 1'b0;
			upcoming_key_events.delete();
			mismatches = 0;
			events_pending <= 0;
		end else begin
			// events leaving now belong to words taken earlier, so check first
			if (out_valid && !out_stall) begin
				if (upcoming_key_events.size() == 0) begin
					$display("%0t: unexpected key event: expected none, %s%02h %0b %0b",
						$time, "got scancode/pressed/last ", scancode, pressed, last);
					mismatches++;
				end else begin
					oldest = upcoming_key_events.pop_front();
					if (oldest.scancode !== scancode) begin
						$display("%0t: scancode mismatch: expected %02h, got %02h",
							$time, oldest.scancode, scancode);
						mismatches++;
					end
					if (oldest.pressed !== pressed) begin
						$display("%0t: pressed mismatch: expected %0b, got %0b",
							$time, oldest.pressed, pressed);
						mismatches++;
					end
					if (oldest.last !== last) begin
						$display("%0t: last mismatch: expected %0b, got %0b",
							$time, oldest.last, last);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_key_events(opcode, row_index, row_bits, table_index, table_code);
			events_pending <= upcoming_key_events.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the key matrix change detector: preloads the scancode table,
// runs directed row scans, then random scans and table writes under several
// idle and stall mixes, and reports the verdict from the event checker.
// ----------------------------------------------------------------------------
module tb_top;
	import kmcd_pkg::*;

	localparam int N_ROWS      = 16;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_WAIT  = 16;
	localparam int STUCK_LIMIT = 3000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       opcode;
	logic [3:0] row_index;
	logic [7:0] row_bits;
	logic [6:0] table_index;
	logic [7:0] table_code;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] scancode;
	logic       pressed;
	logic       last;

	int         mismatches;
	int         events_pending;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_req;
	int         hold_done;
	int         stuck_cycles = 0;
	logic [7:0] sent_bits [N_ROWS];

	key_matrix_change_detector_top #(.ROWS(N_ROWS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .row_index(row_index), .row_bits(row_bits),
		.table_index(table_index), .table_code(table_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.scancode(scancode), .pressed(pressed), .last(last)
	);

	key_event_checker #(.ROWS(N_ROWS)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .row_index(row_index), .row_bits(row_bits),
		.table_index(table_index), .table_code(table_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.scancode(scancode), .pressed(pressed), .last(last),
		.mismatches(mismatches), .events_pending(events_pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// valid stays high between back-to-back words; lowered only on idle
	task automatic send_word(logic op, logic [3:0] row, logic [7:0] bits,
			logic [6:0] tix, logic [7:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		row_index   <= row;
		row_bits    <= bits;
		table_index <= tix;
		table_code  <= code;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_row(logic [3:0] row, logic [7:0] bits);
		sent_bits[row] = bits;
		send_word(OP_ROW, row, bits, 7'($urandom_range(127)), 8'($urandom_range(255)));
	endtask

	task automatic send_table(logic [6:0] tix, logic [7:0] code);
		send_word(OP_TABLE, 4'($urandom_range(15)), 8'($urandom_range(255)), tix, code);
	endtask

	task automatic random_word();
		int         pick;
		logic [3:0] row;
		pick = $urandom_range(99);
		row  = 4'($urandom_range(N_ROWS - 1));
		if (pick < 10)
			send_table(7'($urandom_range(127)), 8'($urandom_range(255)));
		else if (pick < 22)
			send_row(row, sent_bits[row]);
		else if (pick < 55)
			send_row(row, sent_bits[row] ^ (8'h01 << $urandom_range(7)));
		else
			send_row(row, 8'($urandom_range(255)));
	endtask

	// sender goes quiet until the checker has seen every predicted event
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opcode         = OP_ROW;
		row_index      = '0;
		row_bits       = '0;
		table_index    = '0;
		table_code     = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every table entry gets a code so no lookup hits an unwritten one
		send_table(7'd0, 8'h00);
		send_table(7'd1, 8'hFF);
		for (int i = 2; i < N_ROWS*KEYS_PER_ROW; i++)
			send_table(7'(i), 8'($urandom_range(255)));

		// first scan of every row only primes it
		send_row(4'd0, 8'h00);
		for (int r = 1; r < N_ROWS - 1; r++)
			send_row(4'(r), 8'($urandom_range(255)));
		send_row(4'd15, 8'hFF);
		send_row(4'd0, 8'hFF);       // all eight keys released
		send_row(4'd15, 8'h00);      // all eight keys pressed
		send_row(4'd15, 8'h00);      // unchanged row
		send_row(4'd3, sent_bits[3] ^ 8'h80);
		send_row(4'd3, sent_bits[3] ^ 8'h01);
		send_table(7'd8, 8'hA5);     // rewrite, then hit it at once
		send_row(4'd1, sent_bits[1] ^ 8'h80);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			repeat (80) random_word();
			drain();
			if (phase == 0) begin
				// receiver holds off while random row scans keep coming
				hold_req++;
				repeat (20) send_row(4'($urandom_range(N_ROWS - 1)), 8'($urandom_range(255)));
				drain();
			end
		end

		in_valid <= 1'b0;
		drain();
		if (mismatches == 0 && events_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			if (events_pending != 0)
				$display("%0t: %0d key events never arrived", $time, events_pending);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
